>>> design/brq_pkg.sv
// Shared types and constants for the BGR(H) to 8-bit BGR requantiser.
// No dependencies; imported by every module of the block.
package brq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int G_W      = 16;
    localparam int MAX_W    = 15;
    localparam int OUT_W    = 8;
    localparam int NCH      = 3;

    // Channel order is blue, green, red throughout.
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_H      = 2'd1;

    localparam logic [MAX_W-1:0] MAX_BYPASS = 15'd255;
    localparam logic [MAX_W-1:0] MAX_RST    = 15'd1023;
    localparam logic [MAX_W-1:0] RES_RST    = MAX_RST >> 1;

    // Divider: 27-bit dividend, 3 quotient bits per cycle.
    localparam int BITS_PER_STEP = 3;
    localparam int DIV_STEPS     = 9;
    localparam int DVD_W         = BITS_PER_STEP * DIV_STEPS;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_DIV    = 2'd0;
    localparam t_mode MODE_BYPASS = 2'd1;
    localparam t_mode MODE_ZERO   = 2'd2;

    typedef struct packed {
        logic                      frame_start;
        t_mode                     mode;
        logic [NCH-1:0][G_W-1:0]   g;
    } t_item;

endpackage

>>> design/bgrh_to_8bit_bgr_requantizer.sv
// Top level of the BGR(H) to 8-bit BGR requantiser with carried residues.
// Depends on brq_pkg, brq_front, brq_fifo and brq_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one pixel per transfer:
//   frame flag, signed blue, green, red and offset samples. Output channel
//   (o_out_valid / i_out_stall) returns one 8-bit B,G,R result per pixel,
//   in order. Configuration (i_cfg_valid / o_cfg_ready, always ready) holds
//   index 0 = maximum sample, index 1 = offset add enable; other indexes are
//   ignored. Write only while the block is idle.
//   Timing: a pixel enters the queue in the cycle it is transferred. The
//   back end loads one queued pixel, runs the divider over a 27-bit
//   dividend, 3 quotient bits per step, and hands the result to the
//   output register; when the maximum is 255 or 0 it skips the divider.
//   Another pixel is taken only once that result is registered. The output
//   register holds a result while the receiver stalls; the queue of
//   QUEUE_DEPTH pixels then fills and o_in_stall rises once it is full.
//   Reset: maximum 1023, offset add off, all residues 511, queue and output
//   register empty.
module bgrh_to_8bit_bgr_requantizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_frame_start,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_blue_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_green_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_red_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_offset_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [brq_pkg::OUT_W-1:0]           o_blue_out,
    output logic [brq_pkg::OUT_W-1:0]           o_green_out,
    output logic [brq_pkg::OUT_W-1:0]           o_red_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [brq_pkg::MAX_W-1:0]           i_cfg_data
);
    import brq_pkg::*;

    logic [MAX_W-1:0] r_max_sample;
    logic             r_add_h;

    t_item w_push_item;
    t_item w_head_item;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sample <= MAX_RST;
            r_add_h      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_SAMPLE: r_max_sample <= i_cfg_data;
                CFG_ADD_H:      r_add_h      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    brq_front u_front (
        .i_in_valid    (i_in_valid),
        .i_frame_start (i_frame_start),
        .i_blue_in     (i_blue_in),
        .i_green_in    (i_green_in),
        .i_red_in      (i_red_in),
        .i_offset_in   (i_offset_in),
        .i_max_sample  (r_max_sample),
        .i_add_h       (r_add_h),
        .i_q_full      (w_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    brq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    brq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_head_item),
        .i_q_empty    (w_empty),
        .o_pop        (w_pop),
        .i_max_sample (r_max_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_blue_out   (o_blue_out),
        .o_green_out  (o_green_out),
        .o_red_out    (o_red_out)
    );

endmodule

>>> design/brq_front.sv
// Front end: adds the offset sample when enabled, clamps negatives and classifies the pixel.
// Depends on brq_pkg.
module brq_front (
    input  logic                                i_in_valid,
    input  logic                                i_frame_start,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_blue_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_green_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_red_in,
    input  logic signed [brq_pkg::SAMPLE_W-1:0] i_offset_in,
    input  logic [brq_pkg::MAX_W-1:0]           i_max_sample,
    input  logic                                i_add_h,
    input  logic                                i_q_full,
    output logic                                o_in_stall,
    output logic                                o_push,
    output brq_pkg::t_item                      o_item
);
    import brq_pkg::*;

    logic signed [SAMPLE_W-1:0] w_smp [NCH];
    logic signed [SAMPLE_W:0]   w_off;
    logic signed [SAMPLE_W:0]   w_sum [NCH];

    assign w_smp[CH_B] = i_blue_in;
    assign w_smp[CH_G] = i_green_in;
    assign w_smp[CH_R] = i_red_in;

    assign w_off = i_add_h ? {i_offset_in[SAMPLE_W-1], i_offset_in} : '0;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            w_sum[ch] = {w_smp[ch][SAMPLE_W-1], w_smp[ch]} + w_off;
            // sum of two samples peaks at 65534, so 16 bits hold it once clamped
            o_item.g[ch] = w_sum[ch][SAMPLE_W] ? '0 : w_sum[ch][G_W-1:0];
        end
        o_item.frame_start = i_frame_start;
        if (i_max_sample == MAX_BYPASS) begin
            o_item.mode = MODE_BYPASS;
        end else if (i_max_sample == '0) begin
            o_item.mode = MODE_ZERO;
        end else begin
            o_item.mode = MODE_DIV;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

>>> design/brq_fifo.sv
// Short queue of classified pixels between front and back end.
// Depends on brq_pkg.
module brq_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brq_pkg::t_item i_item,
    input  logic           i_pop,
    output brq_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import brq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

>>> design/brq_back.sv
// Back end: per-channel residue state, three radix-8 restoring dividers and
// the output register. Depends on brq_pkg.
module brq_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  brq_pkg::t_item            i_item,
    input  logic                      i_q_empty,
    output logic                      o_pop,
    input  logic [brq_pkg::MAX_W-1:0] i_max_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [brq_pkg::OUT_W-1:0] o_blue_out,
    output logic [brq_pkg::OUT_W-1:0] o_green_out,
    output logic [brq_pkg::OUT_W-1:0] o_red_out
);
    import brq_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    t_mode                r_mode;
    logic [MAX_W-1:0]     r_dvs;
    logic [MAX_W-1:0]     r_residue [NCH];
    logic [MAX_W-1:0]     r_rem     [NCH];
    logic [DVD_W-1:0]     r_dvd     [NCH];
    logic [DVD_W-1:0]     r_quo     [NCH];
    logic [OUT_W-1:0]     r_res     [NCH];
    logic [OUT_W-1:0]     r_out     [NCH];

    logic [MAX_W-1:0]     w_ld_res  [NCH];
    logic [DVD_W-1:0]     w_ld_dvd  [NCH];
    logic [MAX_W-1:0]     w_step_rem [NCH];
    logic [DVD_W-1:0]     w_step_quo [NCH];
    logic                 w_load;
    logic                 w_last;
    logic                 w_out_load;

    function automatic logic [OUT_W-1:0] sat8(logic [DVD_W-1:0] v);
        return (|v[DVD_W-1:OUT_W]) ? '1 : v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat_g(logic [G_W-1:0] v);
        return (|v[G_W-1:OUT_W]) ? '1 : v[OUT_W-1:0];
    endfunction

    assign w_load     = (r_state == ST_IDLE) && !i_q_empty;
    assign w_last     = (r_state == ST_DIV) && (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign o_pop      = w_load;

    // residue after any frame restart, and g*255 + residue
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            w_ld_res[ch] = i_item.frame_start ? (i_max_sample >> 1) : r_residue[ch];
            w_ld_dvd[ch] = ({3'b0, i_item.g[ch], 8'b0} - {11'b0, i_item.g[ch]})
                         + {12'b0, w_ld_res[ch]};
        end
    end

    // three restoring steps per cycle; partial remainder stays below the divisor
    always_comb begin
        logic [MAX_W:0]           t;
        logic [MAX_W-1:0]         rem;
        logic [BITS_PER_STEP-1:0] qb;
        t   = '0;
        rem = '0;
        qb  = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            rem = r_rem[ch];
            for (int k = 0; k < BITS_PER_STEP; k++) begin
                t = {rem, r_dvd[ch][DVD_W-1-k]};
                if (t >= {1'b0, r_dvs}) begin
                    t = t - {1'b0, r_dvs};
                    qb[BITS_PER_STEP-1-k] = 1'b1;
                end else begin
                    qb[BITS_PER_STEP-1-k] = 1'b0;
                end
                rem = t[MAX_W-1:0];
            end
            w_step_rem[ch] = rem;
            w_step_quo[ch] = {r_quo[ch][DVD_W-BITS_PER_STEP-1:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < NCH; ch++) begin
                r_residue[ch] <= RES_RST;
            end
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_load) begin
                        case (i_item.mode)
                            MODE_DIV: begin
                                r_state <= ST_DIV;
                            end
                            MODE_BYPASS: begin
                                for (int ch = 0; ch < NCH; ch++) begin
                                    r_residue[ch] <= w_ld_res[ch];
                                end
                                r_state <= ST_DONE;
                            end
                            default: begin
                                // zero maximum: divide-by-zero clears the residue
                                for (int ch = 0; ch < NCH; ch++) begin
                                    r_residue[ch] <= '0;
                                end
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        for (int ch = 0; ch < NCH; ch++) begin
                            r_residue[ch] <= w_step_rem[ch];
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mode <= i_item.mode;
            r_dvs  <= i_max_sample;
            for (int ch = 0; ch < NCH; ch++) begin
                r_rem[ch] <= '0;
                r_quo[ch] <= '0;
                r_dvd[ch] <= w_ld_dvd[ch];
                r_res[ch] <= (i_item.mode == MODE_BYPASS) ? sat_g(i_item.g[ch]) : '1;
            end
        end else if (r_state == ST_DIV) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_rem[ch] <= w_step_rem[ch];
                r_quo[ch] <= w_step_quo[ch];
                r_dvd[ch] <= r_dvd[ch] << BITS_PER_STEP;
                if (w_last) begin
                    r_res[ch] <= sat8(w_step_quo[ch]);
                end
            end
        end
        if (w_out_load) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_out[ch] <= r_res[ch];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_blue_out  = r_out[CH_B];
    assign o_green_out = r_out[CH_G];
    assign o_red_out   = r_out[CH_R];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("divider ran past its last step");
    a_residue_lt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_mode == MODE_DIV && r_dvs != '0)
        |-> (r_residue[CH_B] < r_dvs && r_residue[CH_G] < r_dvs
             && r_residue[CH_R] < r_dvs))
        else $error("carried residue not below the maximum");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall)
        |=> (r_out_valid && $stable(r_out[CH_B]) && $stable(r_out[CH_G])
             && $stable(r_out[CH_R])))
        else $error("stalled result changed");

endmodule

>>> dv/bgrh_to_8bit_bgr_requantizer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the BGR(H) to 8-bit BGR requantiser.
// Depends on brq_pkg and bgrh_to_8bit_bgr_requantizer; predicts every pixel in-line.
module bgrh_to_8bit_bgr_requantizer_test;
    import brq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int END_WAIT    = 30;
    localparam int PHASE_ITEMS = 110;
    // Unused register indexes; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic                       frame_start;
        logic signed [SAMPLE_W-1:0] blue;
        logic signed [SAMPLE_W-1:0] green;
        logic signed [SAMPLE_W-1:0] red;
        logic signed [SAMPLE_W-1:0] offset;
    } t_pixel;

    typedef struct {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } t_bgr8;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_frame_start;
    logic signed [SAMPLE_W-1:0] i_blue_in;
    logic signed [SAMPLE_W-1:0] i_green_in;
    logic signed [SAMPLE_W-1:0] i_red_in;
    logic signed [SAMPLE_W-1:0] i_offset_in;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [OUT_W-1:0]           o_blue_out;
    logic [OUT_W-1:0]           o_green_out;
    logic [OUT_W-1:0]           o_red_out;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [MAX_W-1:0]           i_cfg_data;

    // Predictor state: mirrors the block's registers and carried remainders.
    logic [MAX_W-1:0] max_sample_q;
    logic             add_h_q;
    logic [MAX_W-1:0] residue_q [NCH];

    t_bgr8 expected_pixels [$];

    int mismatch_count  = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int frames_started  = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_gen     = 0;
    int hold_len     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    bgrh_to_8bit_bgr_requantizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_frame_start (i_frame_start),
        .i_blue_in     (i_blue_in),
        .i_green_in    (i_green_in),
        .i_red_in      (i_red_in),
        .i_offset_in   (i_offset_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_blue_out    (o_blue_out),
        .o_green_out   (o_green_out),
        .o_red_out     (o_red_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_bgr8 want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with none outstanding (blue)", o_blue_out, -1);
            end else begin
                want = expected_pixels.pop_front();
                if (o_blue_out !== want.blue)
                    report_mismatch($sformatf("pixel %0d blue", results_checked),
                                    o_blue_out, want.blue);
                if (o_green_out !== want.green)
                    report_mismatch($sformatf("pixel %0d green", results_checked),
                                    o_green_out, want.green);
                if (o_red_out !== want.red)
                    report_mismatch($sformatf("pixel %0d red", results_checked),
                                    o_red_out, want.red);
                results_checked++;
            end
        end
    end

    function automatic logic [OUT_W-1:0] requant_channel(input int ch,
                                                         input logic signed [SAMPLE_W-1:0] sample,
                                                         input logic signed [SAMPLE_W-1:0] offset);
        int          sum;
        int unsigned level;
        int unsigned wide;
        int unsigned quo;
        sum = int'(sample);
        if (add_h_q)
            sum = sum + int'(offset);
        level = (sum < 0) ? 0 : sum;
        if (max_sample_q != MAX_BYPASS) begin
            // Divide by zero: all-ones quotient, remainder cleared
            if (max_sample_q == '0) begin
                residue_q[ch] = '0;
                return 8'hFF;
            end
            wide = level * 255 + residue_q[ch];
            quo  = wide / max_sample_q;
            residue_q[ch] = MAX_W'(wide - quo * max_sample_q);
            level = quo;
        end
        return (level > 255) ? 8'hFF : level[OUT_W-1:0];
    endfunction

    function automatic t_bgr8 requant_pixel(input t_pixel px);
        t_bgr8 res;
        if (px.frame_start) begin
            for (int ch = 0; ch < NCH; ch++)
                residue_q[ch] = max_sample_q >> 1;
        end
        res.blue  = requant_channel(CH_B, px.blue, px.offset);
        res.green = requant_channel(CH_G, px.green, px.offset);
        res.red   = requant_channel(CH_R, px.red, px.offset);
        return res;
    endfunction

    function automatic t_pixel make_pixel(input logic fs, input int b, input int g,
                                          input int r, input int h);
        t_pixel px;
        px.frame_start = fs;
        px.blue        = b[SAMPLE_W-1:0];
        px.green       = g[SAMPLE_W-1:0];
        px.red         = r[SAMPLE_W-1:0];
        px.offset      = h[SAMPLE_W-1:0];
        return px;
    endfunction

    // Mostly in-range levels, with full-width noise and the signed extremes.
    function automatic int rand_sample(input int unsigned span);
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return -32768;
                    1: return -1;
                    2: return 0;
                    3: return 32767;
                    default: return span;
                endcase
            end
            default: return $urandom_range(span);
        endcase
    endfunction

    function automatic int rand_offset(input int unsigned span);
        if (add_h_q && $urandom_range(9) < 7)
            return int'($urandom_range(span / 4)) - int'(span / 8);
        return $urandom;
    endfunction

    task automatic send_pixel(input t_pixel px);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid    <= 1'b1;
        i_frame_start <= px.frame_start;
        i_blue_in     <= px.blue;
        i_green_in    <= px.green;
        i_red_in      <= px.red;
        i_offset_in   <= px.offset;
        do @(posedge i_clk); while (o_in_stall);
        expected_pixels.push_back(requant_pixel(px));
        pixels_sent++;
        if (px.frame_start)
            frames_started++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Only called with the block idle, so the predictor can follow at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [MAX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_MAX_SAMPLE: max_sample_q = data;
            CFG_ADD_H:      add_h_q      = data[0];
            default:        ;
        endcase
        reg_writes++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 65; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 65; end
            default: begin send_gap_pct = 26; stall_pct = 26; end
        endcase
    endtask

    // Reset values: maximum 1023, offset off, remainders at 511.
    task automatic test_reset_state();
        set_idling(0);
        send_pixel(make_pixel(1'b0, 0, 0, 0, 0));
        send_pixel(make_pixel(1'b0, 1023, -1, -32768, 32767));
        send_pixel(make_pixel(1'b0, 32767, 512, 1, -32768));
        drain_results();
    endtask

    // Offset add, including the widest sum and sums that go negative.
    task automatic test_offset_extremes();
        write_reg(CFG_ADD_H, 15'd1);
        write_reg(CFG_MAX_SAMPLE, 15'd32767);
        set_idling(3);
        send_pixel(make_pixel(1'b1, 32767, 0, -32768, 32767));
        send_pixel(make_pixel(1'b0, 32767, -32768, 100, -32768));
        send_pixel(make_pixel(1'b0, -1, 1, 32767, -1));
        drain_results();
        write_reg(CFG_ADD_H, 15'd0);
    endtask

    task automatic test_max_corners();
        set_idling(0);
        write_reg(CFG_MAX_SAMPLE, 15'd1);
        send_pixel(make_pixel(1'b1, 1, 0, -5, 0));
        send_pixel(make_pixel(1'b0, 2, 1, 32767, 0));
        drain_results();
        // Build up large remainders, then shrink the maximum mid-frame
        write_reg(CFG_MAX_SAMPLE, 15'd32767);
        send_pixel(make_pixel(1'b1, 32766, 32000, 12345, 0));
        send_pixel(make_pixel(1'b0, 32766, 31000, 22222, 0));
        drain_results();
        write_reg(CFG_MAX_SAMPLE, 15'd3);
        send_pixel(make_pixel(1'b0, 0, 1, 2, 0));
        send_pixel(make_pixel(1'b0, 3, 0, 1, 0));
        drain_results();
        // Bypass: plain saturation, remainders left alone but for the frame-start reset
        write_reg(CFG_MAX_SAMPLE, MAX_BYPASS);
        send_pixel(make_pixel(1'b0, 200, 255, 300, 0));
        send_pixel(make_pixel(1'b1, -7, 256, 32767, 0));
        drain_results();
        write_reg(CFG_MAX_SAMPLE, MAX_RST);
        send_pixel(make_pixel(1'b0, 500, 1000, 7, 0));
        drain_results();
        // Zero maximum: everything saturates and remainders clear
        write_reg(CFG_MAX_SAMPLE, 15'd0);
        send_pixel(make_pixel(1'b0, 0, -32768, 77, 0));
        send_pixel(make_pixel(1'b1, 32767, 1, 0, 0));
        drain_results();
        write_reg(CFG_MAX_SAMPLE, MAX_RST);
        write_reg(CFG_SPARE_A, 15'h7FFF);
        write_reg(CFG_SPARE_B, 15'h2AAA);
        send_pixel(make_pixel(1'b0, 1023, 511, 0, 0));
        send_pixel(make_pixel(1'b0, 1, 2, 3, 0));
        drain_results();
    endtask

    task automatic test_random_phase(input int unsigned max_val, input logic add_h,
                                     input int mode);
        int unsigned span;
        write_reg(CFG_MAX_SAMPLE, max_val[MAX_W-1:0]);
        write_reg(CFG_ADD_H, {14'd0, add_h});
        set_idling(mode);
        span = (max_val == 0) ? 255 : max_val;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_pixel(make_pixel(i == 0 || $urandom_range(19) == 0, rand_sample(span),
                                  rand_sample(span), rand_sample(span), rand_offset(span)));
        drain_results();
    endtask

    task automatic test_random_traffic();
        test_random_phase(1023, 1'b0, 0);
        test_random_phase(4095, 1'b1, 1);
        test_random_phase(255, 1'b1, 2);
        test_random_phase(1, 1'b0, 3);
        test_random_phase(32767, 1'b1, 0);
        test_random_phase($urandom_range(32767, 2), 1'($urandom_range(1)), 1);
        test_random_phase(1023, 1'b1, 2);
        test_random_phase($urandom_range(32767, 2), 1'b0, 3);
    endtask

    // Long receiver hold-off fills the queue; then bursts separated by full drains.
    task automatic test_backpressure();
        write_reg(CFG_MAX_SAMPLE, 15'd4095);
        write_reg(CFG_ADD_H, 15'd1);
        set_idling(0);
        hold_len = 300;
        hold_gen = hold_gen + 1;
        for (int i = 0; i < 24; i++)
            send_pixel(make_pixel(i == 0, rand_sample(4095), rand_sample(4095),
                                  rand_sample(4095), rand_offset(4095)));
        drain_results();
        for (int burst = 0; burst < 2; burst++) begin
            set_idling(2);
            for (int i = 0; i < 10; i++)
                send_pixel(make_pixel(1'b0, rand_sample(4095), rand_sample(4095),
                                      rand_sample(4095), rand_offset(4095)));
            drain_results();
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_frame_start = 1'b0;
        i_blue_in     = '0;
        i_green_in    = '0;
        i_red_in      = '0;
        i_offset_in   = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MAX_SAMPLE;
        i_cfg_data    = '0;
        max_sample_q  = MAX_RST;
        add_h_q       = 1'b0;
        for (int ch = 0; ch < NCH; ch++)
            residue_q[ch] = RES_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_offset_extremes();
        test_max_corners();
        test_random_traffic();
        test_backpressure();

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        $display("Covered %0d pixels in %0d frames over %0d register writes,", pixels_sent,
                 frames_started, reg_writes);
        $display("%0d results checked, with bypass, zero-maximum and back-pressure cases.",
                 results_checked);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/brq_pkg.sv
design/brq_front.sv
design/brq_fifo.sv
design/brq_back.sv
design/bgrh_to_8bit_bgr_requantizer.sv
dv/bgrh_to_8bit_bgr_requantizer_test.sv
